FILE: rtl/h264_nal_unit_splitter_defines.svh
// ---------------------------------------------------------------------------
// H.264 NAL unit splitter assertion macros
// Shared concurrent assertion forms, sampled on clk, gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef H264_NAL_UNIT_SPLITTER_DEFINES_SVH
`define H264_NAL_UNIT_SPLITTER_DEFINES_SVH

// same-cycle implication
`define SPL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/h264nal_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// H.264 NAL unit splitter package
// Payload structs, inter-module bundles and fixed constants.
// ---------------------------------------------------------------------------
package h264nal_pkg;

    localparam int BYTE_W      = 8;
    localparam int UNIT_LEN_W  = 12;
    localparam int SEQ_W       = 8;
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = 3;
    localparam int QUEUE_LW    = 4;

    localparam logic [23:0]           START_CODE    = 24'h000001;
    localparam logic [UNIT_LEN_W-1:0] MAX_LEN_RESET = 12'd1400;
    localparam logic [1:0]            FILL_FULL     = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]     out_byte;
        logic                  unit_first;
        logic                  unit_last;
        logic [SEQ_W-1:0]      sequence_number;
        logic [UNIT_LEN_W-1:0] unit_length;
        logic                  overflow_error;
    } result_t;

    typedef struct packed {
        logic [1:0]               count;
        result_t [MAX_RESULTS-1:0] entry;
    } push_t;

    typedef struct packed {
        logic [QUEUE_LW-1:0] level;
    } queue_status_t;

endpackage

FILE: rtl/h264nal_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// H.264 NAL unit splitter parser
// Start code window, unit tracking, length check and result generation.
// ---------------------------------------------------------------------------
module h264nal_parser #(
    parameter int LENGTH_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [h264nal_pkg::UNIT_LEN_W-1:0]    cfg_data,
    input  logic                                  take,
    input  h264nal_pkg::item_t                    item,
    output h264nal_pkg::push_t                    push
);

    localparam int CW = ((LENGTH_BITS > h264nal_pkg::UNIT_LEN_W) ?
                         LENGTH_BITS : h264nal_pkg::UNIT_LEN_W) + 2;
    localparam logic [CW-1:0] LEN_LIMIT = CW'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [h264nal_pkg::UNIT_LEN_W-1:0] max_len_reg;
    logic [23:0]                        window_reg,  window_next;
    logic [1:0]                         fill_reg,    fill_next;
    logic                               inside_reg,  inside_next;
    logic                               first_reg,   first_next;
    logic [LENGTH_BITS-1:0]             len_reg,     len_next;
    logic [h264nal_pkg::SEQ_W-1:0]      seq_reg,     seq_next;
    logic                               halted_reg,  halted_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= h264nal_pkg::MAX_LEN_RESET;
            window_reg  <= '0;
            fill_reg    <= '0;
            inside_reg  <= 1'b0;
            first_reg   <= 1'b0;
            len_reg     <= '0;
            seq_reg     <= '0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_len_reg <= cfg_data;
            end
            window_reg <= window_next;
            fill_reg   <= fill_next;
            inside_reg <= inside_next;
            first_reg  <= first_next;
            len_reg    <= len_next;
            seq_reg    <= seq_next;
            halted_reg <= halted_next;
        end
    end

    always_comb
    begin
        logic [23:0]   new_window;
        logic          start;
        logic          stop;
        logic [CW-1:0] len_k;
        logic [CW-1:0] done_k;
        logic [1:0]    idx;
        logic [7:0]    b;

        window_next = window_reg;
        fill_next   = fill_reg;
        inside_next = inside_reg;
        first_next  = first_reg;
        len_next    = len_reg;
        seq_next    = seq_reg;
        halted_next = halted_reg;
        push        = '0;
        new_window  = {window_reg[15:0], item.data_byte};
        start       = (fill_reg >= 2'd2) && (new_window == h264nal_pkg::START_CODE);
        stop        = 1'b0;
        len_k       = '0;
        done_k      = '0;
        idx         = '0;
        b           = '0;

        if (take && !halted_reg)
        begin
            if (item.end_of_stream)
            begin
                if (inside_reg)
                begin
                    for (int k = 0; k < h264nal_pkg::MAX_RESULTS; k++)
                    begin
                        if ((2'(k) < fill_reg) && !stop)
                        begin
                            len_k  = CW'(len_reg) + CW'(k + 1);
                            done_k = CW'(len_reg) + CW'(k);
                            idx    = fill_reg - 2'(k) - 2'd1;
                            case (idx)
                                2'd0:    b = window_reg[7:0];
                                2'd1:    b = window_reg[15:8];
                                default: b = window_reg[23:16];
                            endcase
                            push.count = 2'(k + 1);
                            if ((len_k > CW'(max_len_reg)) || (len_k > LEN_LIMIT))
                            begin
                                push.entry[k].sequence_number = seq_reg;
                                push.entry[k].unit_length     =
                                    done_k[h264nal_pkg::UNIT_LEN_W-1:0];
                                push.entry[k].overflow_error  = 1'b1;
                                halted_next = 1'b1;
                                stop        = 1'b1;
                            end
                            else
                            begin
                                push.entry[k].out_byte        = b;
                                push.entry[k].unit_first      = first_reg && (k == 0);
                                push.entry[k].unit_last       = (idx == 2'd0);
                                push.entry[k].sequence_number = seq_reg;
                                push.entry[k].unit_length     =
                                    len_k[h264nal_pkg::UNIT_LEN_W-1:0];
                                if (idx == 2'd0)
                                begin
                                    seq_next = seq_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                window_next = '0;
                fill_next   = '0;
                inside_next = 1'b0;
                first_next  = 1'b0;
                len_next    = '0;
            end
            else
            begin
                if ((fill_reg == h264nal_pkg::FILL_FULL) && inside_reg)
                begin
                    len_k      = CW'(len_reg) + CW'(1);
                    push.count = 2'd1;
                    if ((len_k > CW'(max_len_reg)) || (len_k > LEN_LIMIT))
                    begin
                        push.entry[0].sequence_number = seq_reg;
                        push.entry[0].unit_length     =
                            h264nal_pkg::UNIT_LEN_W'(CW'(len_reg));
                        push.entry[0].overflow_error  = 1'b1;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        push.entry[0].out_byte        = window_reg[23:16];
                        push.entry[0].unit_first      = first_reg;
                        push.entry[0].unit_last       = start;
                        push.entry[0].sequence_number = seq_reg;
                        push.entry[0].unit_length     =
                            len_k[h264nal_pkg::UNIT_LEN_W-1:0];
                        len_next   = len_k[LENGTH_BITS-1:0];
                        first_next = 1'b0;
                        if (start)
                        begin
                            seq_next    = seq_reg + 1'b1;
                            inside_next = 1'b0;
                            len_next    = '0;
                        end
                    end
                end
                window_next = new_window;
                if (fill_reg != h264nal_pkg::FILL_FULL)
                begin
                    fill_next = fill_reg + 2'd1;
                end
                if (start)
                begin
                    inside_next = 1'b1;
                    first_next  = 1'b1;
                    len_next    = '0;
                end
            end
        end
    end

endmodule

FILE: rtl/h264nal_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// H.264 NAL unit splitter result queue
// Takes up to three results per cycle, hands out one per transaction.
// ---------------------------------------------------------------------------
module h264nal_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  h264nal_pkg::push_t         push,
    input  logic                       pop,
    output h264nal_pkg::result_t       head,
    output h264nal_pkg::queue_status_t status
);

    h264nal_pkg::result_t mem_reg [h264nal_pkg::QUEUE_DEPTH];

    logic [h264nal_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [h264nal_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [h264nal_pkg::QUEUE_LW-1:0] level_reg,  level_next;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < h264nal_pkg::MAX_RESULTS; k++)
        begin
            if (2'(k) < push.count)
            begin
                mem_reg[wr_ptr_reg + h264nal_pkg::QUEUE_AW'(k)] <= push.entry[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + h264nal_pkg::QUEUE_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + h264nal_pkg::QUEUE_AW'(pop);
        level_next  = level_reg + h264nal_pkg::QUEUE_LW'(push.count)
                      - h264nal_pkg::QUEUE_LW'(pop);
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.level = level_reg;

endmodule

FILE: rtl/h264_nal_unit_splitter.sv
`timescale 1ns / 1ps
// Results are queued by the transaction that causes them.
// Throughput: one byte per cycle; end of stream yields up to three results,
// drained one per cycle while result_ready is high, from an eight-entry queue
// that gates input ready. Reset (rst_n low, asynchronous): window, unit state,
// counters, halt and queue clear; maximum unit length returns to 1400.
// ---------------------------------------------------------------------------
// H.264 NAL unit splitter
// Splits an Annex B byte stream into NAL units with sequence and length.
// ---------------------------------------------------------------------------
`include "h264_nal_unit_splitter_defines.svh"

module h264_nal_unit_splitter #(
    parameter int LENGTH_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [h264nal_pkg::UNIT_LEN_W-1:0] cfg_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  h264nal_pkg::item_t                 item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output h264nal_pkg::result_t               result
);

    h264nal_pkg::push_t         push;
    h264nal_pkg::queue_status_t status;
    logic                       take;
    logic                       pop;

    assign cfg_ready    = 1'b1;
    assign item_ready   = status.level <= h264nal_pkg::QUEUE_LW'(
                              h264nal_pkg::QUEUE_DEPTH - h264nal_pkg::MAX_RESULTS);
    assign take         = item_valid && item_ready;
    assign result_valid = status.level != '0;
    assign pop          = result_valid && result_ready;

    h264nal_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (item),
        .push      (push)
    );

    h264nal_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (result),
        .status (status)
    );

    `SPL_ASSERT_NOW(a_room_for_burst, item_ready, status.level <= 4'd5, "queue lacks room")
    `SPL_ASSERT_NOW(a_first_length, result_valid && result.unit_first, result.unit_length == 12'd1, "first byte length")
    `SPL_ASSERT_NEXT(a_error_final, pop && result.overflow_error, !result_valid, "result after error")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// H.264 NAL unit splitter testbench
// Feeds Annex B byte streams over valid/ready and compares every output
// transaction with a local predictor of the splitter: window, unit framing,
// sequence and length counters, the length ceiling register and the halt on
// overflow. A short scripted stream comes first, then random start-code
// framed units under changing back-pressure and ceilings, and finally the
// ceiling is squeezed until the block overflows and halts.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int OPENING_ROWS = 25;
    localparam h264nal_pkg::item_t EOS_ITEM = '{8'h00, 1'b1};

    typedef struct packed {
        h264nal_pkg::item_t   stim;
        logic                 typed;
        h264nal_pkg::result_t want;
    } script_row_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [h264nal_pkg::UNIT_LEN_W-1:0] cfg_data = '0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    h264nal_pkg::item_t   item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    h264nal_pkg::result_t result;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // splitter predictor state
    logic [23:0]                        held_window = '0;
    logic [1:0]                         held_count = '0;
    logic                               unit_open = 1'b0;
    logic                               first_due = 1'b0;
    logic [h264nal_pkg::UNIT_LEN_W-1:0] unit_count = '0;
    logic [h264nal_pkg::SEQ_W-1:0]      unit_seq = '0;
    logic                               locked_up = 1'b0;
    logic [h264nal_pkg::UNIT_LEN_W-1:0] len_ceiling = h264nal_pkg::MAX_LEN_RESET;

    h264nal_pkg::result_t step_results[$];
    h264nal_pkg::result_t unit_bytes_due[$];

    script_row_t opening [OPENING_ROWS] = '{
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, 8'd0, 12'd1, 1'b0}},
        '{'{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'd0, 12'd2, 1'b0}},
        '{'{8'h00, 1'b0}, 1'b1, '{8'h01, 1'b0, 1'b0, 8'd0, 12'd3, 1'b0}},
        '{'{8'h01, 1'b0}, 1'b1, '{8'hFF, 1'b0, 1'b1, 8'd0, 12'd4, 1'b0}},
        '{'{8'h80, 1'b0}, 1'b0, '0},
        '{EOS_ITEM, 1'b0, '0},
        '{'{8'h12, 1'b0}, 1'b0, '0},
        '{'{8'h34, 1'b0}, 1'b0, '0},
        '{EOS_ITEM, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0}, 1'b0, '0},
        '{EOS_ITEM, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0}, 1'b0, '0},
        '{EOS_ITEM, 1'b0, '0}
    };

    h264_nal_unit_splitter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("h264_nal_unit_splitter test failed");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic deliver_byte(input logic [7:0] b, input logic last);
        logic [h264nal_pkg::UNIT_LEN_W:0] next_len;
        h264nal_pkg::result_t r;
        next_len = {1'b0, unit_count} + 1'b1;
        r = '0;
        r.sequence_number = unit_seq;
        if (next_len > {1'b0, len_ceiling} ||
            next_len > {1'b0, {h264nal_pkg::UNIT_LEN_W{1'b1}}})
        begin
            locked_up = 1'b1;
            r.unit_length = unit_count;
            r.overflow_error = 1'b1;
            step_results.push_back(r);
            return 1'b0;
        end
        r.out_byte = b;
        r.unit_first = first_due;
        r.unit_last = last;
        r.unit_length = next_len[h264nal_pkg::UNIT_LEN_W-1:0];
        step_results.push_back(r);
        unit_count = next_len[h264nal_pkg::UNIT_LEN_W-1:0];
        first_due = 1'b0;
        if (last)
        begin
            unit_seq = unit_seq + 1'b1;
            unit_open = 1'b0;
            unit_count = '0;
        end
        return 1'b1;
    endfunction

    function automatic void split_step(input h264nal_pkg::item_t it);
        logic [23:0] next_window;
        logic        starts;
        int          i;
        step_results.delete();
        if (locked_up)
            return;
        if (it.end_of_stream)
        begin
            if (unit_open)
            begin
                for (i = int'(held_count); i > 0; i--)
                begin
                    if (!deliver_byte(held_window[8*(i-1) +: 8], i == 1))
                        return;
                end
            end
            held_window = '0;
            held_count = '0;
            unit_open = 1'b0;
            first_due = 1'b0;
            unit_count = '0;
            return;
        end
        next_window = {held_window[15:0], it.data_byte};
        starts = (held_count >= 2'd2) && (next_window == h264nal_pkg::START_CODE);
        if (held_count == h264nal_pkg::FILL_FULL && unit_open)
        begin
            if (!deliver_byte(held_window[23:16], starts))
                return;
        end
        held_window = next_window;
        if (held_count != h264nal_pkg::FILL_FULL)
            held_count = held_count + 1'b1;
        if (starts)
        begin
            unit_open = 1'b1;
            first_due = 1'b1;
            unit_count = '0;
        end
    endfunction

    task automatic send_item(input h264nal_pkg::item_t it, input logic typed,
                             input h264nal_pkg::result_t want, inout int produced);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        split_step(it);
        if (typed && step_results.size() > 0)
            step_results[0] = want;
        foreach (step_results[k])
            unit_bytes_due.push_back(step_results[k]);
        if (step_results.size() > 0)
            produced++;
    endtask

    task automatic feed(input logic [7:0] b, input logic eos, inout int produced);
        h264nal_pkg::item_t it;
        it.data_byte = b;
        it.end_of_stream = eos;
        send_item(it, 1'b0, '0, produced);
    endtask

    task automatic drain_unit_bytes();
        item_valid <= 1'b0;
        @(posedge clk);
        while (unit_bytes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [h264nal_pkg::UNIT_LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        len_ceiling = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random_units(input int target);
        int produced;
        int kind;
        int n;
        produced = 0;
        while (produced < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                feed(8'h00, 1'b0, produced);
                feed(8'h00, 1'b0, produced);
                feed(8'h01, 1'b0, produced);
                n = $urandom_range(0, 10);
                repeat (n)
                begin
                    if ($urandom_range(0, 3) == 0)
                        feed(8'($urandom_range(0, 1)), 1'b0, produced);
                    else
                        feed(8'($urandom_range(0, 255)), 1'b0, produced);
                end
                if ($urandom_range(0, 3) == 0)
                    feed(8'($urandom_range(0, 255)), 1'b1, produced);
            end
            else if (kind < 88)
            begin
                feed(8'h00, 1'b0, produced);
                if ($urandom_range(0, 1) == 1)
                begin
                    feed(8'h00, 1'b0, produced);
                    feed(8'($urandom_range(2, 255)), 1'b0, produced);
                end
                else
                    feed(8'h01, 1'b0, produced);
            end
            else if (kind < 96)
            begin
                repeat ($urandom_range(1, 4))
                    feed(8'($urandom_range(0, 255)), 1'b0, produced);
            end
            else
                feed(8'($urandom_range(0, 255)), 1'b1, produced);
        end
        feed(8'($urandom_range(0, 255)), 1'b1, produced);
    endtask

    always @(posedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin : result_check
        h264nal_pkg::result_t due;
        if (rst_n && result_valid && result_ready)
        begin
            if (unit_bytes_due.size() == 0)
                note_mismatch($sformatf("unexpected transaction, byte %02h", result.out_byte));
            else
            begin
                due = unit_bytes_due.pop_front();
                if (result.out_byte !== due.out_byte)
                    note_mismatch($sformatf("out_byte %02h, want %02h",
                                            result.out_byte, due.out_byte));
                if (result.unit_first !== due.unit_first)
                    note_mismatch($sformatf("unit_first %b, want %b",
                                            result.unit_first, due.unit_first));
                if (result.unit_last !== due.unit_last)
                    note_mismatch($sformatf("unit_last %b, want %b",
                                            result.unit_last, due.unit_last));
                if (result.sequence_number !== due.sequence_number)
                    note_mismatch($sformatf("sequence_number %0d, want %0d",
                                            result.sequence_number, due.sequence_number));
                if (result.unit_length !== due.unit_length)
                    note_mismatch($sformatf("unit_length %0d, want %0d",
                                            result.unit_length, due.unit_length));
                if (result.overflow_error !== due.overflow_error)
                    note_mismatch($sformatf("overflow_error %b, want %b",
                                            result.overflow_error, due.overflow_error));
            end
        end
    end

    initial
    begin : stimulus
        int ignored;
        int r;
        ignored = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22;
        recv_stall_pct = 56;
        for (r = 0; r < OPENING_ROWS; r++)
            send_item(opening[r].stim, opening[r].typed, opening[r].want, ignored);
        drain_unit_bytes();

        write_max_len(12'd4095);
        run_random_units(25);
        drain_unit_bytes();

        send_idle_pct = 56;
        recv_stall_pct = 22;
        write_max_len(12'($urandom_range(100, 1400)));
        run_random_units(25);
        drain_unit_bytes();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_max_len(12'($urandom_range(100, 4095)));
        run_random_units(25);
        drain_unit_bytes();

        // units of exactly the ceiling
        write_max_len(12'd3);
        feed(8'h00, 1'b0, ignored);
        feed(8'h00, 1'b0, ignored);
        feed(8'h01, 1'b0, ignored);
        feed(8'h00, 1'b0, ignored);
        feed(8'h00, 1'b0, ignored);
        feed(8'h01, 1'b0, ignored);
        feed(8'h00, 1'b1, ignored);
        drain_unit_bytes();

        // ceiling below a start code: overflow, then halt
        write_max_len(12'd2);
        feed(8'h00, 1'b0, ignored);
        feed(8'h00, 1'b0, ignored);
        feed(8'h01, 1'b0, ignored);
        feed(8'h7E, 1'b0, ignored);
        feed(8'h7F, 1'b0, ignored);
        feed(8'hC3, 1'b0, ignored);
        feed(8'h5A, 1'b0, ignored);
        feed(8'h00, 1'b0, ignored);
        feed(8'h00, 1'b0, ignored);
        feed(8'h01, 1'b0, ignored);
        feed(8'hA5, 1'b0, ignored);
        feed(8'h00, 1'b1, ignored);
        drain_unit_bytes();
        repeat (10) @(posedge clk);

        if (unit_bytes_due.size() != 0)
            note_mismatch($sformatf("%0d transactions never arrived", unit_bytes_due.size()));
        if (mismatch_count == 0)
            $display("h264_nal_unit_splitter test passed");
        else
            $display("h264_nal_unit_splitter test failed");
        $finish;
    end

endmodule
